/* hw/rtl/ftn_pkg.sv */
package ftn_pkg;

    localparam int COORD_W          = 16;
    localparam int IDX_W            = 12;
    localparam int NORM_W           = 16;
    localparam int FRAC_BITS        = 14;
    localparam int VERTEX_DEPTH_DEF = 4096;
    localparam int ADDR_MAX_W       = 17;
    localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1 << FRAC_BITS);

    localparam logic [1:0] KIND_POS   = 2'd0;
    localparam logic [1:0] KIND_TRI   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    typedef struct packed {
        logic go;
        logic is_div;
    } rd_req_t;

    function automatic logic [ADDR_MAX_W-1:0] vidx(input logic [IDX_W-1:0] raw,
                                                   input int depth);
        logic [ADDR_MAX_W-1:0] r;
        int k;
        int step;
        r = ADDR_MAX_W'(raw);
        for (k = IDX_W - 1; k >= 0; k--)
        begin
            step = depth << k;
            if (step < (1 << IDX_W) && int'(r) >= step)
            begin
                r = r - ADDR_MAX_W'(step);
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/flat_triangle_normal_generator.sv */
// Flat triangle normal generator.
// A command word is taken at a rising edge where start is high and busy is low.
// A position write (kind 0) completes at that edge and busy stays low.
// A normal read (kind 2) moves to state S_RD, which registers its word onto the outputs.
// A triangle (kind 1) reads three positions, forms the cross product on a
// shared multiplier, then runs one square root (31 steps) and three
// divisions (15 steps each) on one shared shift-subtract unit, and writes
// the normal to all three corners; the divisions are skipped when the cross
// product is zero. Busy falls in the same cycle that the word appears.
// A new mesh (kind 3) sweeps the valid marks, one entry per cycle, over all
// VERTEX_DEPTH entries, and the same sweep runs right after reset.
// Each result word is shown for exactly one cycle with done high; the receiver
// cannot stall it. Reset is asynchronous and active low.
module flat_triangle_normal_generator #(
    parameter int VERTEX_DEPTH = ftn_pkg::VERTEX_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            kind,
    input  logic [ftn_pkg::IDX_W-1:0]             vertex_index,
    input  logic signed [ftn_pkg::COORD_W-1:0]    pos_x,
    input  logic signed [ftn_pkg::COORD_W-1:0]    pos_y,
    input  logic signed [ftn_pkg::COORD_W-1:0]    pos_z,
    input  logic [ftn_pkg::IDX_W-1:0]             corner_a,
    input  logic [ftn_pkg::IDX_W-1:0]             corner_b,
    input  logic [ftn_pkg::IDX_W-1:0]             corner_c,
    output logic                                  done,
    output logic signed [ftn_pkg::NORM_W-1:0]     normal_x,
    output logic signed [ftn_pkg::NORM_W-1:0]     normal_y,
    output logic signed [ftn_pkg::NORM_W-1:0]     normal_z,
    output logic                                  degenerate,
    output logic                                  from_read
);
    import ftn_pkg::*;

    localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_PB, S_PC, S_PCAP, S_MUL, S_SCALE,
        S_SQ, S_SQRT, S_DIV, S_WR
    } state_t;

    state_t state_reg;

    logic [3*COORD_W-1:0] pos_mem [VERTEX_DEPTH];
    logic [3*NORM_W-1:0]  nrm_mem [VERTEX_DEPTH];
    logic                 val_mem [VERTEX_DEPTH];
    logic [3*COORD_W-1:0] pos_rd_reg;
    logic [3*NORM_W-1:0]  nrm_rd_reg;
    logic                 val_rd_reg;

    logic [IDX_W-1:0]     cb_reg;
    logic [IDX_W-1:0]     cc_reg;
    logic [IDX_W-1:0]     ca_reg;
    logic [AW-1:0]        clr_reg;
    logic [2:0]           cnt_reg;
    logic [3*COORD_W-1:0] pa_reg;
    logic [3*COORD_W-1:0] pb_reg;
    logic [3*COORD_W-1:0] pc_reg;
    logic signed [33:0]   hold_reg;
    logic signed [33:0]   cross_reg [3];
    logic [29:0]          mag_reg [3];
    logic                 neg_reg [3];
    logic [61:0]          sum_reg;
    logic [30:0]          len_reg;
    logic signed [NORM_W-1:0] nrm_reg [3];
    logic                 degen_reg;
    logic                 rd_go_reg;
    logic                 rd_div_reg;

    logic                 done_reg;
    logic signed [NORM_W-1:0] nx_reg;
    logic signed [NORM_W-1:0] ny_reg;
    logic signed [NORM_W-1:0] nz_reg;
    logic                 degenerate_reg;
    logic                 from_read_reg;

    logic                 accept;
    logic [ADDR_MAX_W-1:0] vi_full;
    logic [ADDR_MAX_W-1:0] pos_rd_full;
    logic [ADDR_MAX_W-1:0] wr_full;
    logic [IDX_W-1:0]     pos_rd_raw;
    logic [IDX_W-1:0]     wr_raw;
    logic signed [16:0]   e1 [3];
    logic signed [16:0]   e2 [3];
    logic signed [31:0]   mul_a;
    logic signed [31:0]   mul_b;
    logic signed [63:0]   prod;
    logic [33:0]          cmag [3];
    logic [33:0]          mor;
    logic [2:0]           shamt;
    rd_req_t              rd_req;
    logic                 rd_done;
    logic [30:0]          root;
    logic [FRAC_BITS:0]   quot;
    logic [29:0]          div_num;
    logic signed [NORM_W-1:0] qs;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        unique case (state_reg)
            S_PB:    pos_rd_raw = cb_reg;
            S_PC:    pos_rd_raw = cc_reg;
            default: pos_rd_raw = corner_a;
        endcase
        unique case (cnt_reg[1:0])
            2'd0:    wr_raw = ca_reg;
            2'd1:    wr_raw = cb_reg;
            default: wr_raw = cc_reg;
        endcase
        vi_full     = vidx(vertex_index, VERTEX_DEPTH);
        pos_rd_full = vidx(pos_rd_raw, VERTEX_DEPTH);
        wr_full     = vidx(wr_raw, VERTEX_DEPTH);
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_POS)
        begin
            pos_mem[vi_full[AW-1:0]] <= {pos_x, pos_y, pos_z};
        end
        pos_rd_reg <= pos_mem[pos_rd_full[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR)
        begin
            nrm_mem[wr_full[AW-1:0]] <= {nrm_reg[0], nrm_reg[1], nrm_reg[2]};
        end
        nrm_rd_reg <= nrm_mem[vi_full[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            val_mem[clr_reg] <= 1'b0;
        end
        else if (state_reg == S_WR)
        begin
            val_mem[wr_full[AW-1:0]] <= 1'b1;
        end
        val_rd_reg <= val_mem[vi_full[AW-1:0]];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = {pb_reg[(2-i)*COORD_W+COORD_W-1], pb_reg[(2-i)*COORD_W +: COORD_W]}
                  - {pa_reg[(2-i)*COORD_W+COORD_W-1], pa_reg[(2-i)*COORD_W +: COORD_W]};
            e2[i] = {pc_reg[(2-i)*COORD_W+COORD_W-1], pc_reg[(2-i)*COORD_W +: COORD_W]}
                  - {pa_reg[(2-i)*COORD_W+COORD_W-1], pa_reg[(2-i)*COORD_W +: COORD_W]};
            cmag[i] = cross_reg[i][33] ? 34'(-cross_reg[i]) : 34'(cross_reg[i]);
        end
        mor = cmag[0] | cmag[1] | cmag[2];
        priority if (mor[33]) shamt = 3'd4;
        else if (mor[32])     shamt = 3'd3;
        else if (mor[31])     shamt = 3'd2;
        else if (mor[30])     shamt = 3'd1;
        else                  shamt = 3'd0;
        mul_a = 32'sd0;
        mul_b = 32'sd0;
        if (state_reg == S_MUL)
        begin
            unique case (cnt_reg)
                3'd0:    begin mul_a = 32'(e1[1]); mul_b = 32'(e2[2]); end
                3'd1:    begin mul_a = 32'(e1[2]); mul_b = 32'(e2[1]); end
                3'd2:    begin mul_a = 32'(e1[2]); mul_b = 32'(e2[0]); end
                3'd3:    begin mul_a = 32'(e1[0]); mul_b = 32'(e2[2]); end
                3'd4:    begin mul_a = 32'(e1[0]); mul_b = 32'(e2[1]); end
                3'd5:    begin mul_a = 32'(e1[1]); mul_b = 32'(e2[0]); end
                default: begin mul_a = 32'sd0; mul_b = 32'sd0; end
            endcase
        end
        else if (state_reg == S_SQ)
        begin
            unique case (cnt_reg)
                3'd0:    begin mul_a = {2'b00, mag_reg[0]}; mul_b = {2'b00, mag_reg[0]}; end
                3'd1:    begin mul_a = {2'b00, mag_reg[1]}; mul_b = {2'b00, mag_reg[1]}; end
                3'd2:    begin mul_a = {2'b00, mag_reg[2]}; mul_b = {2'b00, mag_reg[2]}; end
                default: begin mul_a = 32'sd0; mul_b = 32'sd0; end
            endcase
        end
        unique case (cnt_reg[1:0])
            2'd0:    div_num = mag_reg[0];
            2'd1:    div_num = mag_reg[1];
            default: div_num = mag_reg[2];
        endcase
        unique case (cnt_reg[1:0])
            2'd0:    qs = neg_reg[0] ? -NORM_W'({1'b0, quot}) : NORM_W'({1'b0, quot});
            2'd1:    qs = neg_reg[1] ? -NORM_W'({1'b0, quot}) : NORM_W'({1'b0, quot});
            default: qs = neg_reg[2] ? -NORM_W'({1'b0, quot}) : NORM_W'({1'b0, quot});
        endcase
    end

    assign rd_req.go     = rd_go_reg;
    assign rd_req.is_div = rd_div_reg;

    ftn_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ftn_root_div u_root_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (rd_req),
        .radicand (sum_reg),
        .num      (div_num),
        .den      (len_reg),
        .done     (rd_done),
        .root     (root),
        .quot     (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            cnt_reg    <= 3'd0;
            rd_go_reg  <= 1'b0;
            rd_div_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg  <= 1'b0;
            rd_go_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(VERTEX_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ca_reg  <= corner_a;
                        cb_reg  <= corner_b;
                        cc_reg  <= corner_c;
                        cnt_reg <= 3'd0;
                        clr_reg <= '0;
                        unique case (kind)
                            KIND_TRI:   state_reg <= S_PB;
                            KIND_READ:  state_reg <= S_RD;
                            KIND_CLEAR: state_reg <= S_CLEAR;
                            default:    state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_RD:
                begin
                    done_reg       <= 1'b1;
                    from_read_reg  <= 1'b1;
                    degenerate_reg <= 1'b0;
                    if (val_rd_reg)
                    begin
                        nx_reg <= nrm_rd_reg[3*NORM_W-1:2*NORM_W];
                        ny_reg <= nrm_rd_reg[2*NORM_W-1:NORM_W];
                        nz_reg <= nrm_rd_reg[NORM_W-1:0];
                    end
                    else
                    begin
                        nx_reg <= '0;
                        ny_reg <= NORM_ONE;
                        nz_reg <= '0;
                    end
                    state_reg <= S_IDLE;
                end
                S_PB:
                begin
                    pa_reg    <= pos_rd_reg;
                    state_reg <= S_PC;
                end
                S_PC:
                begin
                    pb_reg    <= pos_rd_reg;
                    state_reg <= S_PCAP;
                end
                S_PCAP:
                begin
                    pc_reg    <= pos_rd_reg;
                    cnt_reg   <= 3'd0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg != 3'd0)
                    begin
                        if (cnt_reg[0])
                        begin
                            hold_reg <= prod[33:0];
                        end
                        else
                        begin
                            unique case (cnt_reg)
                                3'd2:    cross_reg[0] <= hold_reg - prod[33:0];
                                3'd4:    cross_reg[1] <= hold_reg - prod[33:0];
                                default: cross_reg[2] <= hold_reg - prod[33:0];
                            endcase
                        end
                    end
                    if (cnt_reg == 3'd6)
                    begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= 30'(cmag[i] >> shamt);
                        neg_reg[i] <= cross_reg[i][33];
                    end
                    sum_reg   <= 62'd0;
                    cnt_reg   <= 3'd0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg != 3'd0)
                    begin
                        sum_reg <= sum_reg + {2'b00, prod[59:0]};
                    end
                    if (cnt_reg == 3'd3)
                    begin
                        rd_go_reg  <= 1'b1;
                        rd_div_reg <= 1'b0;
                        state_reg  <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (rd_done)
                    begin
                        len_reg <= root;
                        cnt_reg <= 3'd0;
                        if (root == 31'd0)
                        begin
                            degen_reg  <= 1'b1;
                            nrm_reg[0] <= '0;
                            nrm_reg[1] <= NORM_ONE;
                            nrm_reg[2] <= '0;
                            state_reg  <= S_WR;
                        end
                        else
                        begin
                            degen_reg  <= 1'b0;
                            rd_go_reg  <= 1'b1;
                            rd_div_reg <= 1'b1;
                            state_reg  <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (rd_done)
                    begin
                        unique case (cnt_reg[1:0])
                            2'd0:    nrm_reg[0] <= qs;
                            2'd1:    nrm_reg[1] <= qs;
                            default: nrm_reg[2] <= qs;
                        endcase
                        if (cnt_reg == 3'd2)
                        begin
                            cnt_reg   <= 3'd0;
                            state_reg <= S_WR;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + 3'd1;
                            rd_go_reg <= 1'b1;
                        end
                    end
                end
                S_WR:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd2)
                    begin
                        done_reg       <= 1'b1;
                        from_read_reg  <= 1'b0;
                        degenerate_reg <= degen_reg;
                        nx_reg         <= nrm_reg[0];
                        ny_reg         <= nrm_reg[1];
                        nz_reg         <= nrm_reg[2];
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done       = done_reg;
    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;
    assign degenerate = degenerate_reg;
    assign from_read  = from_read_reg;

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result word longer than one cycle");
    a_tri_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_TRI) |=> busy) else $error("triangle not started");
    a_degen_tri: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> !from_read) else $error("degenerate flag on read");
    a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
        rd_done |-> (state_reg == S_SQRT || state_reg == S_DIV))
        else $error("unit finished outside its states");
`endif

endmodule

/* hw/rtl/ftn_mul.sv */
module ftn_mul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] prod
);

    logic signed [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

/* hw/rtl/ftn_root_div.sv */
module ftn_root_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ftn_pkg::rd_req_t          req,
    input  logic [61:0]               radicand,
    input  logic [29:0]               num,
    input  logic [30:0]               den,
    output logic                      done,
    output logic [30:0]               root,
    output logic [ftn_pkg::FRAC_BITS:0] quot
);
    import ftn_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic        mode_reg;
    logic [4:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [61:0] rad_reg;
    logic [30:0] acc_reg;
    logic [30:0] den_reg;
    logic [32:0] a_op;
    logic [32:0] b_op;
    logic [33:0] diff;
    logic        ge;
    logic [32:0] new_rem;

    always_comb
    begin
        a_op    = mode_reg ? rem_reg : {rem_reg[30:0], rad_reg[61:60]};
        b_op    = mode_reg ? {2'b00, den_reg} : {acc_reg, 2'b01};
        diff    = {1'b0, a_op} - {1'b0, b_op};
        ge      = !diff[33];
        new_rem = ge ? diff[32:0] : a_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                mode_reg <= req.is_div;
                cnt_reg  <= req.is_div ? 5'(FRAC_BITS) : 5'd30;
                rem_reg  <= req.is_div ? {3'b000, num} : 33'd0;
                rad_reg  <= radicand;
                acc_reg  <= 31'd0;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                acc_reg <= {acc_reg[29:0], ge};
                rad_reg <= {rad_reg[59:0], 2'b00};
                rem_reg <= mode_reg ? {new_rem[31:0], 1'b0} : new_rem;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = acc_reg;
    assign quot = acc_reg[FRAC_BITS:0];

`ifndef SYNTHESIS
    a_no_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.go |-> !busy_reg) else $error("request while busy");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without work");
`endif

endmodule

/* tb/tb.sv */
module tb;
    import ftn_pkg::*;

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        bit degen;
        bit rd;
    } normal_word_t;

    class normal_scoreboard;
        longint vpos[4096][3];
        logic signed [15:0] vnorm[4096][3];
        bit vvalid[4096];
        normal_word_t pending[$];
        int errors;

        function void shrink(inout longint v[6], input int n);
            longint unsigned mx;
            longint unsigned m;
            int s;
            mx = 0;
            s = 0;
            for (int i = 0; i < n; i++)
            begin
                m = v[i] < 0 ? -v[i] : v[i];
                if (m > mx)
                    mx = m;
            end
            while ((mx >> s) >= (64'd1 << 30))
                s++;
            for (int i = 0; i < n; i++)
            begin
                m = (v[i] < 0 ? -v[i] : v[i]) >> s;
                v[i] = v[i] < 0 ? -longint'(m) : longint'(m);
            end
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function void note(logic [1:0] k, int vi, logic signed [15:0] px,
                           logic signed [15:0] py, logic signed [15:0] pz,
                           int ca, int cb, int cc);
            normal_word_t w;
            longint e[6];
            longint x[6];
            longint unsigned sum;
            longint unsigned len;
            longint unsigned q;
            w = '{0, 0, 0, 0, 0};
            case (k)
                KIND_POS:
                begin
                    vpos[vi][0] = px;
                    vpos[vi][1] = py;
                    vpos[vi][2] = pz;
                end
                KIND_CLEAR:
                begin
                    foreach (vvalid[i])
                        vvalid[i] = 0;
                end
                KIND_READ:
                begin
                    w.rd = 1;
                    if (vvalid[vi])
                    begin
                        w.nx = vnorm[vi][0];
                        w.ny = vnorm[vi][1];
                        w.nz = vnorm[vi][2];
                    end
                    else
                        w.ny = NORM_ONE;
                    pending = {pending, w};
                end
                default:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e[i] = vpos[cb][i] - vpos[ca][i];
                        e[3 + i] = vpos[cc][i] - vpos[ca][i];
                    end
                    shrink(e, 6);
                    x = '{0, 0, 0, 0, 0, 0};
                    x[0] = e[1] * e[5] - e[2] * e[4];
                    x[1] = e[2] * e[3] - e[0] * e[5];
                    x[2] = e[0] * e[4] - e[1] * e[3];
                    shrink(x, 3);
                    sum = 0;
                    for (int i = 0; i < 3; i++)
                        sum += longint'(x[i] * x[i]);
                    len = root(sum);
                    if (len == 0)
                    begin
                        w.degen = 1;
                        w.ny = NORM_ONE;
                    end
                    else
                    begin
                        q = ((x[0] < 0 ? -x[0] : x[0]) << FRAC_BITS) / len;
                        w.nx = x[0] < 0 ? -16'(q) : 16'(q);
                        q = ((x[1] < 0 ? -x[1] : x[1]) << FRAC_BITS) / len;
                        w.ny = x[1] < 0 ? -16'(q) : 16'(q);
                        q = ((x[2] < 0 ? -x[2] : x[2]) << FRAC_BITS) / len;
                        w.nz = x[2] < 0 ? -16'(q) : 16'(q);
                    end
                    foreach (vnorm[i])
                        if (i == ca || i == cb || i == cc)
                        begin
                            vnorm[i][0] = w.nx;
                            vnorm[i][1] = w.ny;
                            vnorm[i][2] = w.nz;
                            vvalid[i] = 1;
                        end
                    pending = {pending, w};
                end
            endcase
        endfunction

        function void check(normal_word_t got);
            normal_word_t w;
            if (pending.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.nx !== w.nx)
            begin
                $error("normal_x expected %0d actual %0d", w.nx, got.nx);
                errors++;
            end
            if (got.ny !== w.ny)
            begin
                $error("normal_y expected %0d actual %0d", w.ny, got.ny);
                errors++;
            end
            if (got.nz !== w.nz)
            begin
                $error("normal_z expected %0d actual %0d", w.nz, got.nz);
                errors++;
            end
            if (got.degen !== w.degen)
            begin
                $error("degenerate expected %0d actual %0d", w.degen, got.degen);
                errors++;
            end
            if (got.rd !== w.rd)
            begin
                $error("from_read expected %0d actual %0d", w.rd, got.rd);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] kind;
    logic [IDX_W-1:0] vertex_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [IDX_W-1:0] corner_a;
    logic [IDX_W-1:0] corner_b;
    logic [IDX_W-1:0] corner_c;
    logic done;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic degenerate;
    logic from_read;

    normal_scoreboard sb;
    bit written[4096];
    int written_list[$];
    bit gaps_on;
    int quiet;
    int n_items;
    int n_tri;
    int n_read;
    int n_clear;
    int n_words;

    flat_triangle_normal_generator i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .vertex_index(vertex_index),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .corner_a(corner_a),
        .corner_b(corner_b),
        .corner_c(corner_c),
        .done(done),
        .normal_x(normal_x),
        .normal_y(normal_y),
        .normal_z(normal_z),
        .degenerate(degenerate),
        .from_read(from_read)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check('{normal_x, normal_y, normal_z, degenerate, from_read});
            n_words++;
        end
        if ((start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 30000)
        begin
            $display("flat_triangle_normal_generator: mismatch");
            $finish;
        end
    end

    task automatic send(logic [1:0] k, int vi, logic signed [15:0] px,
                        logic signed [15:0] py, logic signed [15:0] pz,
                        int ca, int cb, int cc);
        if (gaps_on && $urandom_range(99) < 24)
        begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        kind <= k;
        vertex_index <= IDX_W'(vi);
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        corner_a <= IDX_W'(ca);
        corner_b <= IDX_W'(cb);
        corner_c <= IDX_W'(cc);
        start <= 1;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sb.note(k, vi & 4095, px, py, pz, ca & 4095, cb & 4095, cc & 4095);
        n_items++;
        if (k == KIND_TRI)
            n_tri++;
        if (k == KIND_READ)
            n_read++;
        if (k == KIND_CLEAR)
            n_clear++;
        @(negedge clk);
    endtask

    task automatic put_pos(int vi, logic signed [15:0] px, logic signed [15:0] py,
                           logic signed [15:0] pz);
        send(KIND_POS, vi, px, py, pz, $urandom, $urandom, $urandom);
        if (!written[vi])
        begin
            written[vi] = 1;
            written_list = {written_list, vi};
        end
    endtask

    function automatic int pick_written();
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    function automatic logic signed [15:0] rand_coord();
        if ($urandom_range(1) == 0)
            return 16'($urandom);
        return $signed(16'($urandom_range(64))) - 16'sd32;
    endfunction

    initial
    begin
        int a;
        int b;
        int c;
        int r;
        sb = new();
        gaps_on = 1;
        rst_n = 0;
        start = 0;
        kind = KIND_POS;
        vertex_index = 0;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        corner_a = 0;
        corner_b = 0;
        corner_c = 0;
        repeat (3) @(negedge clk);
        rst_n = 1;

        send(KIND_READ, 0, 0, 0, 0, 0, 0, 0);
        put_pos(0, 16'sh8000, 16'sh8000, 16'sh8000);
        put_pos(1, 16'sh7fff, 16'sh8000, 16'sh8000);
        put_pos(2, 16'sh8000, 16'sh7fff, 16'sh7fff);
        put_pos(4095, 16'sh7fff, 16'sh7fff, 16'sh8000);
        put_pos(3, 0, 0, 0);
        put_pos(4, 256, 256, 256);
        send(KIND_TRI, 0, 0, 0, 0, 0, 1, 2);
        send(KIND_TRI, 0, 0, 0, 0, 1, 2, 4095);
        send(KIND_TRI, 0, 0, 0, 0, 3, 4, 4);
        send(KIND_TRI, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_TRI, 0, 0, 0, 0, 0, 3, 4);
        send(KIND_READ, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_READ, 4095, 0, 0, 0, 0, 0, 0);
        send(KIND_READ, 3, 0, 0, 0, 0, 0, 0);
        send(KIND_READ, 2048, 0, 0, 0, 0, 0, 0);
        send(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_READ, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_READ, 4095, 0, 0, 0, 0, 0, 0);
        send(KIND_TRI, 0, 0, 0, 0, 4095, 0, 1);
        send(KIND_READ, 1, 0, 0, 0, 0, 0, 0);

        for (int i = 0; i < 900; i++)
        begin
            gaps_on = (i < 300 || i >= 450);
            r = $urandom_range(99);
            if (r < 25)
                put_pos($urandom_range(4095), rand_coord(), rand_coord(), rand_coord());
            else if (r < 70)
            begin
                a = pick_written();
                b = pick_written();
                c = $urandom_range(9) == 0 ? a : pick_written();
                send(KIND_TRI, $urandom, rand_coord(), rand_coord(), rand_coord(), a, b, c);
            end
            else if (r < 98)
            begin
                a = $urandom_range(1) ? pick_written() : $urandom_range(4095);
                send(KIND_READ, a, rand_coord(), rand_coord(), rand_coord(),
                     $urandom, $urandom, $urandom);
            end
            else
                send(KIND_CLEAR, $urandom, rand_coord(), rand_coord(), rand_coord(),
                     $urandom, $urandom, $urandom);
        end
        start <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);

        $display("Covered %0d commands: %0d triangles, %0d normal reads, %0d mesh clears.",
                 n_items, n_tri, n_read, n_clear);
        $display("Checked %0d result words with %0d field errors.", n_words, sb.errors);
        if (sb.errors == 0)
            $display("flat_triangle_normal_generator: match");
        else
            $display("flat_triangle_normal_generator: mismatch");
        $finish;
    end
endmodule
